// ===== hw/rtl/tps_pkg.sv =====
// Shared types and codes for the target pursuit step unit.
package tps_pkg;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_SQRT,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_SQ,
    ST_LEN_RT,
    ST_DST_SQ,
    ST_DST_RT,
    ST_PRE_INIT,
    ST_PRE_SHIFT,
    ST_UP_MUL,
    ST_NRM_SQ,
    ST_NRM_RT,
    ST_NUM_MUL,
    ST_QDIV,
    ST_RET,
    ST_STP_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CALL_LV,
    CALL_RIGHT,
    CALL_UP,
    CALL_LOOK,
    CALL_STEP
  } call_t;

  localparam logic REG_MOVE_SPEED = 1'b0;
  localparam logic REG_LIMIT_DIST = 1'b1;

endpackage

// ===== hw/rtl/target_pursuit_step_unit.sv =====
// Top level of the target pursuit step unit: sequencer, state and ports.
// Each beat on the input channel turns the stored basis to face the target point and, when
// the old distance to the target reaches limit_distance, steps the position forward by
// move_speed * time_step along the new look row. One result beat follows each input
// beat. The unit takes one item at a time: in_ready is high only while idle. All arithmetic
// of an item runs through the single shared multiply / square-root / divide unit, and each
// vector is brought into range by a normalizing shift before it is scaled to length.
module target_pursuit_step_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic        [15:0] in_time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_look_x,
  output logic signed [31:0] out_look_y,
  output logic signed [31:0] out_look_z,
  output logic        [31:0] out_target_distance,
  output logic               out_moved,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic        [31:0] cfg_data
);

  localparam logic signed [31:0] ONE = 32'sh1 << FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  tps_pkg::state_t    state_r, state_nxt;
  tps_pkg::call_t     call_r;
  logic               issued_r;
  logic [1:0]         idx_r;
  logic [1:0]         row_r;
  logic [31:0]        speed_r;
  logic [31:0]        limit_r;
  logic signed [31:0] basis_r [9];
  logic signed [31:0] pos_r [3];
  logic               moved_r;

  logic signed [32:0] d_r [3];
  logic [15:0]        ts_r;
  logic [31:0]        len_r [3];
  logic [31:0]        dist_r;
  logic [31:0]        s_r;
  logic [65:0]        acc_r;
  logic signed [63:0] vec_r [3];
  logic signed [63:0] up_r [3];
  logic [62:0]        mag_r [3];
  logic [2:0]         neg_r;
  logic [27:0]        pmag_r [3];
  logic [28:0]        n_r;
  logic [63:0]        num_r;
  logic signed [32:0] res_r [3];

  tps_pkg::alu_req_t  alu_req;
  tps_pkg::alu_rsp_t  alu_rsp;
  logic               done;

  logic [3:0]         bidx;
  logic signed [31:0] bsel;
  logic [31:0]        bmag;
  logic signed [32:0] dsel;
  logic [32:0]        dneg;
  logic [31:0]        dmag;
  logic               over;
  logic [31:0]        dist_val;
  logic [62:0]        m01;
  logic [62:0]        m_max;
  logic               pre_zero;
  logic               pre_ok;
  logic               pre_go;
  logic [47:0]        st_sum;
  logic [31:0]        q;
  logic signed [63:0] up_pos;
  logic signed [63:0] up_neg;

  tps_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign done     = alu_rsp.done;
  assign bidx     = {1'b0, row_r, 1'b0} + {2'b00, row_r} + {2'b00, idx_r};
  assign bsel     = basis_r[bidx];
  assign bmag     = bsel[31] ? (~bsel + 32'd1) : bsel;
  assign dsel     = d_r[idx_r];
  assign dneg     = ~dsel + 33'd1;
  assign dmag     = dsel[32] ? dneg[31:0] : dsel[31:0];
  assign over     = |acc_r[65:64];
  assign dist_val = over ? 32'hffff_ffff : alu_rsp.res[31:0];
  assign m01      = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign m_max    = (m01 > mag_r[2]) ? m01 : mag_r[2];
  assign pre_zero = (m_max == '0);
  assign pre_ok   = (m_max[62:28] == '0) && m_max[27];
  assign pre_go   = pre_zero || pre_ok;
  assign st_sum   = alu_rsp.res[47:0] + 48'd32768;
  assign q        = alu_rsp.res[31:0];
  assign up_pos   = $signed(alu_rsp.res);
  assign up_neg   = -$signed(alu_rsp.res);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tps_pkg::ST_IDLE:      if (in_valid) state_nxt = tps_pkg::ST_LEN_SQ;
      tps_pkg::ST_LEN_SQ:    if (done && idx_r == 2'd2) state_nxt = tps_pkg::ST_LEN_RT;
      tps_pkg::ST_LEN_RT: begin
        if (done) state_nxt = (row_r == 2'd2) ? tps_pkg::ST_DST_SQ : tps_pkg::ST_LEN_SQ;
      end
      tps_pkg::ST_DST_SQ:    if (done && idx_r == 2'd2) state_nxt = tps_pkg::ST_DST_RT;
      tps_pkg::ST_DST_RT:    if (over || done) state_nxt = tps_pkg::ST_PRE_INIT;
      tps_pkg::ST_PRE_INIT:  state_nxt = tps_pkg::ST_PRE_SHIFT;
      tps_pkg::ST_PRE_SHIFT: begin
        if (call_r == tps_pkg::CALL_LV) begin
          if (pre_go) state_nxt = tps_pkg::ST_UP_MUL;
        end else if (pre_zero) begin
          state_nxt = tps_pkg::ST_RET;
        end else if (pre_ok) begin
          state_nxt = tps_pkg::ST_NRM_SQ;
        end
      end
      tps_pkg::ST_UP_MUL:    if (done && idx_r == 2'd3) state_nxt = tps_pkg::ST_PRE_INIT;
      tps_pkg::ST_NRM_SQ:    if (done && idx_r == 2'd2) state_nxt = tps_pkg::ST_NRM_RT;
      tps_pkg::ST_NRM_RT:    if (done) state_nxt = tps_pkg::ST_NUM_MUL;
      tps_pkg::ST_NUM_MUL:   if (done) state_nxt = tps_pkg::ST_QDIV;
      tps_pkg::ST_QDIV: begin
        if (done) state_nxt = (idx_r == 2'd2) ? tps_pkg::ST_RET : tps_pkg::ST_NUM_MUL;
      end
      tps_pkg::ST_RET: begin
        case (call_r)
          tps_pkg::CALL_LOOK: state_nxt = moved_r ? tps_pkg::ST_STP_MUL : tps_pkg::ST_OUT;
          tps_pkg::CALL_STEP: state_nxt = tps_pkg::ST_OUT;
          default:            state_nxt = tps_pkg::ST_PRE_INIT;
        endcase
      end
      tps_pkg::ST_STP_MUL:   if (done) state_nxt = tps_pkg::ST_PRE_INIT;
      tps_pkg::ST_OUT:       if (out_ready) state_nxt = tps_pkg::ST_IDLE;
      default:               state_nxt = tps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = tps_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_r)
      tps_pkg::ST_IDLE: in_ready = 1'b1;
      tps_pkg::ST_OUT:  out_valid = 1'b1;
      tps_pkg::ST_LEN_SQ: begin
        alu_req.start = !issued_r;
        alu_req.a     = {32'b0, bmag};
        alu_req.b     = {32'b0, bmag};
      end
      tps_pkg::ST_DST_SQ: begin
        alu_req.start = !issued_r;
        alu_req.a     = {32'b0, dmag};
        alu_req.b     = {32'b0, dmag};
      end
      tps_pkg::ST_LEN_RT, tps_pkg::ST_NRM_RT: begin
        alu_req.start = !issued_r;
        alu_req.op    = tps_pkg::ALU_SQRT;
        alu_req.a     = acc_r[63:0];
      end
      tps_pkg::ST_DST_RT: begin
        alu_req.start = !issued_r && !over;
        alu_req.op    = tps_pkg::ALU_SQRT;
        alu_req.a     = acc_r[63:0];
      end
      tps_pkg::ST_UP_MUL: begin
        alu_req.start = !issued_r;
        case (idx_r)
          2'd0: begin
            alu_req.a = {36'b0, pmag_r[0]};
            alu_req.b = {36'b0, pmag_r[1]};
          end
          2'd1: begin
            alu_req.a = {36'b0, pmag_r[0]};
            alu_req.b = {36'b0, pmag_r[0]};
          end
          2'd2: begin
            alu_req.a = {36'b0, pmag_r[2]};
            alu_req.b = {36'b0, pmag_r[2]};
          end
          default: begin
            alu_req.a = {36'b0, pmag_r[1]};
            alu_req.b = {36'b0, pmag_r[2]};
          end
        endcase
      end
      tps_pkg::ST_NRM_SQ: begin
        alu_req.start = !issued_r;
        alu_req.a     = {36'b0, pmag_r[idx_r]};
        alu_req.b     = {36'b0, pmag_r[idx_r]};
      end
      tps_pkg::ST_NUM_MUL: begin
        alu_req.start = !issued_r;
        alu_req.a     = {35'b0, pmag_r[idx_r], 1'b0};
        alu_req.b     = {32'b0, s_r};
      end
      tps_pkg::ST_QDIV: begin
        alu_req.start = !issued_r;
        alu_req.op    = tps_pkg::ALU_DIV;
        alu_req.a     = num_r;
        alu_req.b     = {34'b0, n_r, 1'b0};
      end
      tps_pkg::ST_STP_MUL: begin
        alu_req.start = !issued_r;
        alu_req.a     = {32'b0, speed_r};
        alu_req.b     = {48'b0, ts_r};
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tps_pkg::ST_IDLE;
      call_r   <= tps_pkg::CALL_LV;
      issued_r <= 1'b0;
      idx_r    <= '0;
      row_r    <= '0;
      speed_r  <= '0;
      limit_r  <= '0;
      moved_r  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        basis_r[i] <= ((i % 4) == 0) ? ONE : 32'sh0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      issued_r <= done ? 1'b0 : (alu_req.start ? 1'b1 : issued_r);
      if (cfg_we) begin
        unique case (cfg_idx)
          tps_pkg::REG_MOVE_SPEED: speed_r <= cfg_data;
          tps_pkg::REG_LIMIT_DIST: limit_r <= cfg_data;
          default:                 speed_r <= speed_r;
        endcase
      end
      case (state_r)
        tps_pkg::ST_IDLE: begin
          if (in_valid) begin
            idx_r <= '0;
            row_r <= '0;
          end
        end
        tps_pkg::ST_LEN_SQ, tps_pkg::ST_DST_SQ, tps_pkg::ST_NRM_SQ, tps_pkg::ST_QDIV: begin
          if (done) idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        end
        tps_pkg::ST_LEN_RT: begin
          if (done) row_r <= row_r + 2'd1;
        end
        tps_pkg::ST_DST_RT: begin
          if (over || done) begin
            moved_r <= dist_val >= limit_r;
            call_r  <= tps_pkg::CALL_LV;
          end
        end
        tps_pkg::ST_PRE_SHIFT: begin
          if (pre_go) idx_r <= '0;
        end
        tps_pkg::ST_UP_MUL: begin
          if (done) begin
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd3) call_r <= tps_pkg::CALL_RIGHT;
          end
        end
        tps_pkg::ST_RET: begin
          case (call_r)
            tps_pkg::CALL_RIGHT: begin
              for (int i = 0; i < 3; i++) basis_r[i] <= sat32(36'(res_r[i]));
              call_r <= tps_pkg::CALL_UP;
            end
            tps_pkg::CALL_UP: begin
              for (int i = 0; i < 3; i++) basis_r[3 + i] <= sat32(36'(res_r[i]));
              call_r <= tps_pkg::CALL_LOOK;
            end
            tps_pkg::CALL_LOOK: begin
              for (int i = 0; i < 3; i++) basis_r[6 + i] <= sat32(36'(res_r[i]));
            end
            tps_pkg::CALL_STEP: begin
              for (int i = 0; i < 3; i++) begin
                pos_r[i] <= sat32(36'(pos_r[i]) + 36'(res_r[i]));
              end
            end
            default: begin
              call_r <= call_r;
            end
          endcase
        end
        tps_pkg::ST_STP_MUL: begin
          if (done) call_r <= tps_pkg::CALL_STEP;
        end
        default: begin
          idx_r <= idx_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tps_pkg::ST_IDLE: begin
        if (in_valid) begin
          d_r[0] <= 33'(in_target_x) - 33'(pos_r[0]);
          d_r[1] <= 33'(in_target_y) - 33'(pos_r[1]);
          d_r[2] <= 33'(in_target_z) - 33'(pos_r[2]);
          ts_r   <= in_time_step;
          acc_r  <= '0;
        end
      end
      tps_pkg::ST_LEN_SQ, tps_pkg::ST_DST_SQ, tps_pkg::ST_NRM_SQ: begin
        if (done) acc_r <= acc_r + {2'b00, alu_rsp.res};
      end
      tps_pkg::ST_LEN_RT: begin
        if (done) begin
          len_r[row_r] <= alu_rsp.res[31:0];
          acc_r        <= '0;
        end
      end
      tps_pkg::ST_DST_RT: begin
        if (over || done) begin
          dist_r <= dist_val;
          for (int i = 0; i < 3; i++) vec_r[i] <= 64'(d_r[i]);
        end
      end
      tps_pkg::ST_PRE_INIT: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= vec_r[i][63] ? 63'(-vec_r[i]) : vec_r[i][62:0];
          neg_r[i] <= vec_r[i][63];
        end
      end
      tps_pkg::ST_PRE_SHIFT: begin
        if (pre_go) begin
          acc_r <= '0;
          for (int i = 0; i < 3; i++) begin
            pmag_r[i] <= mag_r[i][27:0];
            if (pre_zero) res_r[i] <= '0;
          end
        end else if (m_max[62:28] != '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      tps_pkg::ST_UP_MUL: begin
        if (done) begin
          case (idx_r)
            2'd0: up_r[0] <= (neg_r[0] ^ neg_r[1]) ? up_pos : up_neg;
            2'd1: up_r[1] <= up_pos;
            2'd2: up_r[1] <= up_r[1] + up_pos;
            default: begin
              up_r[2]  <= (neg_r[1] ^ neg_r[2]) ? up_pos : up_neg;
              vec_r[0] <= 64'(d_r[2]);
              vec_r[1] <= '0;
              vec_r[2] <= -64'(d_r[0]);
              s_r      <= len_r[0];
            end
          endcase
        end
      end
      tps_pkg::ST_NRM_RT: begin
        if (done) n_r <= alu_rsp.res[28:0];
      end
      tps_pkg::ST_NUM_MUL: begin
        if (done) num_r <= alu_rsp.res + {35'b0, n_r};
      end
      tps_pkg::ST_QDIV: begin
        if (done) res_r[idx_r] <= neg_r[idx_r] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
      tps_pkg::ST_RET: begin
        case (call_r)
          tps_pkg::CALL_RIGHT: begin
            for (int i = 0; i < 3; i++) vec_r[i] <= up_r[i];
            s_r <= len_r[1];
          end
          tps_pkg::CALL_UP: begin
            for (int i = 0; i < 3; i++) vec_r[i] <= 64'(d_r[i]);
            s_r <= len_r[2];
          end
          default: begin
            s_r <= s_r;
          end
        endcase
      end
      tps_pkg::ST_STP_MUL: begin
        if (done) begin
          s_r <= st_sum[47:16];
          for (int i = 0; i < 3; i++) vec_r[i] <= 64'(basis_r[6 + i]);
        end
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  assign out_pos_x           = pos_r[0];
  assign out_pos_y           = pos_r[1];
  assign out_pos_z           = pos_r[2];
  assign out_look_x          = basis_r[6];
  assign out_look_y          = basis_r[7];
  assign out_look_z          = basis_r[8];
  assign out_target_distance = dist_r;
  assign out_moved           = moved_r;

endmodule

// ===== hw/rtl/tps_alu.sv =====
// Shared iterative multiply, square root and divide unit.
module tps_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  tps_pkg::alu_req_t  req,
  output tps_pkg::alu_rsp_t  rsp
);

  localparam int DIGIT_W    = 8;
  localparam int MUL_STEPS  = 5;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;
  localparam int CNT_W      = 6;

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  tps_pkg::alu_op_t    op_r;
  logic [63:0]         x_r;
  logic [63:0]         y_r;
  logic [63:0]         z_r;

  logic [71:0]         mul_pp;
  logic [63:0]         sq_t;
  logic                sq_ge;
  logic [64:0]         dv_rem;
  logic                dv_ge;
  logic [64:0]         dv_sub;

  assign mul_pp = {8'b0, x_r} * {64'b0, z_r[DIGIT_W-1:0]};
  assign sq_t   = y_r + z_r;
  assign sq_ge  = x_r >= sq_t;
  assign dv_rem = {y_r, x_r[63]};
  assign dv_ge  = dv_rem >= {1'b0, z_r};
  assign dv_sub = dv_rem - {1'b0, z_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        case (req.op)
          tps_pkg::ALU_MUL:  cnt_r <= CNT_W'(MUL_STEPS - 1);
          tps_pkg::ALU_SQRT: cnt_r <= CNT_W'(SQRT_STEPS - 1);
          tps_pkg::ALU_DIV:  cnt_r <= CNT_W'(DIV_STEPS - 1);
          default:           cnt_r <= '0;
        endcase
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      x_r  <= req.a;
      y_r  <= '0;
      case (req.op)
        tps_pkg::ALU_SQRT: z_r <= 64'h4000_0000_0000_0000;
        default:           z_r <= req.b;
      endcase
    end else if (busy_r) begin
      case (op_r)
        tps_pkg::ALU_MUL: begin
          y_r <= y_r + mul_pp[63:0];
          x_r <= x_r << DIGIT_W;
          z_r <= z_r >> DIGIT_W;
        end
        tps_pkg::ALU_SQRT: begin
          if (sq_ge) begin
            x_r <= x_r - sq_t;
            y_r <= (y_r >> 1) + z_r;
          end else begin
            y_r <= y_r >> 1;
          end
          z_r <= z_r >> 2;
        end
        tps_pkg::ALU_DIV: begin
          y_r <= dv_ge ? dv_sub[63:0] : dv_rem[63:0];
          x_r <= {x_r[62:0], dv_ge};
        end
        default: begin
          y_r <= y_r;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = (op_r == tps_pkg::ALU_DIV) ? x_r : y_r;

endmodule

// ===== hw/rtl/tps_checker.sv =====
// Port-level checks for the target pursuit step unit, bound to the top level.
module tps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] in_target_x,
  input logic signed [31:0] in_target_y,
  input logic signed [31:0] in_target_z,
  input logic        [15:0] in_time_step,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_pos_y,
  input logic signed [31:0] out_pos_z,
  input logic signed [31:0] out_look_x,
  input logic signed [31:0] out_look_y,
  input logic signed [31:0] out_look_z,
  input logic        [31:0] out_target_distance,
  input logic               out_moved,
  input logic               cfg_we,
  input logic               cfg_idx,
  input logic        [31:0] cfg_data
);

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("unit not busy after an input beat");

  a_drop_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid && in_ready))
    else $error("result beat repeated or unit not idle after delivery");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_pos_z) && $stable(out_look_x) && $stable(out_look_y)
      && $stable(out_look_z) && $stable(out_target_distance) && $stable(out_moved)))
    else $error("stalled result beat changed");

endmodule

bind target_pursuit_step_unit tps_checker u_tps_checker (.*);
